// ----- hw/rtl/sdlm_pkg.sv -----
// ----------------------------------------------------------------------------
// sdlm_pkg
// Types and constants shared by the segmented direct lookup map: transfer
// payloads, operation and status codes, register indexes and the kind view.
// ----------------------------------------------------------------------------
package sdlm_pkg;

    // field widths
    localparam int MAX_KINDS  = 4;
    localparam int KIND_W     = 2;
    localparam int HANDLE_W   = 29;
    localparam int COUNT_W    = 11;
    localparam int VALUE_W    = 16;
    // window base plus offset: three counts plus one offset, all 11 bit
    localparam int POS_W      = 13;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = 16'hFFFF;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_ADD    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_CONFLICT  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        REG_KIND0_FIRST = 3'd0,
        REG_KIND0_COUNT = 3'd1,
        REG_KIND1_FIRST = 3'd2,
        REG_KIND1_COUNT = 3'd3,
        REG_KIND2_FIRST = 3'd4,
        REG_KIND2_COUNT = 3'd5,
        REG_KIND3_FIRST = 3'd6,
        REG_KIND3_COUNT = 3'd7
    } cfg_reg_t;

    typedef struct packed
    {
        op_t                 operation;
        logic [KIND_W-1:0]   event_kind;
        logic [HANDLE_W-1:0] sender_handle;
        logic [VALUE_W-1:0]  new_value;
    } req_t;

    typedef struct packed
    {
        status_t            status;
        logic [VALUE_W-1:0] found_value;
    } rsp_t;

    // per-kind window settings as seen by the datapath
    typedef struct packed
    {
        logic [MAX_KINDS-1:0][HANDLE_W-1:0] first;
        logic [MAX_KINDS-1:0][COUNT_W-1:0]  count;
        logic [MAX_KINDS-1:0][POS_W-1:0]    base;
    } kind_cfg_t;

endpackage

// ----- hw/rtl/sdlm_ram.sv -----
// ----------------------------------------------------------------------------
// sdlm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sdlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port, old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/sdlm_cfg.sv -----
// ----------------------------------------------------------------------------
// sdlm_cfg
// Register bank for the per-kind handle windows, with registered window bases
// formed as the running sum of the lower kinds' handle counts.
// ----------------------------------------------------------------------------
module sdlm_cfg
    import sdlm_pkg::*;
#(
    parameter int KIND_COUNT = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output kind_cfg_t             kcfg
);

    logic [HANDLE_W-1:0] first_reg [MAX_KINDS];
    logic [COUNT_W-1:0]  count_reg [MAX_KINDS];
    logic [MAX_KINDS-1:0][POS_W-1:0] base_reg;
    logic [MAX_KINDS-1:0][POS_W-1:0] base_next;

    cfg_reg_t          reg_idx;
    logic [KIND_W-1:0] sel_kind;
    logic              sel_count;
    logic              wr_en;

    // address decode, shared by reads and writes
    always_comb
    begin
        reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
        unique case (reg_idx)
            REG_KIND0_FIRST: begin sel_kind = 2'd0; sel_count = 1'b0; end
            REG_KIND0_COUNT: begin sel_kind = 2'd0; sel_count = 1'b1; end
            REG_KIND1_FIRST: begin sel_kind = 2'd1; sel_count = 1'b0; end
            REG_KIND1_COUNT: begin sel_kind = 2'd1; sel_count = 1'b1; end
            REG_KIND2_FIRST: begin sel_kind = 2'd2; sel_count = 1'b0; end
            REG_KIND2_COUNT: begin sel_kind = 2'd2; sel_count = 1'b1; end
            REG_KIND3_FIRST: begin sel_kind = 2'd3; sel_count = 1'b0; end
            REG_KIND3_COUNT: begin sel_kind = 2'd3; sel_count = 1'b1; end
            default:         begin sel_kind = 2'd0; sel_count = 1'b0; end
        endcase
    end

    assign wr_en = psel & penable & pwrite;

    // window registers, only for the kinds that exist
    for (genvar k = 0; k < MAX_KINDS; k++)
    begin : g_kind
        if (k < KIND_COUNT)
        begin : g_used
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    first_reg[k] <= '0;
                    count_reg[k] <= '0;
                end
                else if (wr_en && (sel_kind == KIND_W'(k)))
                begin
                    if (sel_count)
                    begin
                        count_reg[k] <= pwdata[COUNT_W-1:0];
                    end
                    else
                    begin
                        first_reg[k] <= pwdata[HANDLE_W-1:0];
                    end
                end
            end
        end
        else
        begin : g_unused
            assign first_reg[k] = '0;
            assign count_reg[k] = '0;
        end
    end

    // running sum of lower counts
    always_comb
    begin
        base_next[0] = '0;
        for (int k = 1; k < MAX_KINDS; k++)
        begin
            base_next[k] = base_next[k-1] + POS_W'(count_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    // view for the datapath
    always_comb
    begin
        for (int k = 0; k < MAX_KINDS; k++)
        begin
            kcfg.first[k] = first_reg[k];
            kcfg.count[k] = count_reg[k];
        end
        kcfg.base = base_reg;
    end

    // read back
    assign prdata = sel_count ? CFG_DATA_W'(count_reg[sel_kind])
                              : CFG_DATA_W'(first_reg[sel_kind]);

endmodule

// ----- hw/rtl/segmented_direct_lookup_map.sv -----
// Each accepted request passes stage 1, stage 2 and the output register.
// Throughput: one request per cycle while req_stall is low; the two-port table
// does read-modify-write over two stages, forwarding write data to the next read.
// Reset: window registers clear to zero, single values to empty, and a clearing
// sweep writes empty to every one of the TABLE_DEPTH (1024 by default) entries
// while req_stall is held high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
// segmented_direct_lookup_map
// Maps an event kind and handle onto a shared lookup table of 16-bit values,
// with per-kind handle windows and a single value for kinds with no window.
// ----------------------------------------------------------------------------
module segmented_direct_lookup_map
    import sdlm_pkg::*;
#(
    parameter int KIND_COUNT  = 4,
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    kind_cfg_t kcfg;

    // clearing sweep
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;

    // pipeline control
    logic advance;
    logic req_accept;
    logic fire;

    // stage 1: window check and table read
    logic                s1_valid_reg;
    req_t                s1_req_reg;
    logic                kind_ok;
    logic [HANDLE_W-1:0] first_sel;
    logic [COUNT_W-1:0]  count_sel;
    logic [POS_W-1:0]    base_sel;
    logic [HANDLE_W:0]   diff;
    logic                in_win;
    logic [POS_W-1:0]    pos;
    logic [PW-1:0]       pos_wide;
    logic                pos_ok;
    logic                s1_single;
    logic                s1_range;
    logic [AW-1:0]       s1_addr;

    // stage 2: decide and write back
    logic               s2_valid_reg;
    op_t                s2_op_reg;
    logic [KIND_W-1:0]  s2_kind_reg;
    logic [VALUE_W-1:0] s2_value_reg;
    logic               s2_single_reg;
    logic               s2_range_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic [VALUE_W-1:0] tab_rdata;
    logic [VALUE_W-1:0] tab_stored;
    logic [VALUE_W-1:0] single_stored;
    logic               tab_wr;
    logic               single_wr;
    rsp_t               result;

    // forwarding of the last table write
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [VALUE_W-1:0] fwd_data_reg;

    // single values of kinds with no window
    logic [VALUE_W-1:0] single_reg [MAX_KINDS];

    // table port
    logic               tab_we;
    logic [AW-1:0]      tab_waddr;
    logic [VALUE_W-1:0] tab_wdata;

    // output register
    logic rsp_valid_reg;
    rsp_t rsp_data_reg;

    sdlm_cfg #(
        .KIND_COUNT (KIND_COUNT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .kcfg    (kcfg)
    );

    assign pready = 1'b1;

    // handshake
    assign advance    = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = clearing_reg || !advance;
    assign req_accept = req_valid && !req_stall;
    assign fire       = advance && s2_valid_reg;

    // clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_req_reg <= req_data;
        end
    end

    // window check and table address
    always_comb
    begin
        kind_ok   = 32'(s1_req_reg.event_kind) < 32'(KIND_COUNT);
        first_sel = kcfg.first[s1_req_reg.event_kind];
        count_sel = kcfg.count[s1_req_reg.event_kind];
        base_sel  = kcfg.base[s1_req_reg.event_kind];
        s1_single = (count_sel == '0);
        diff      = {1'b0, s1_req_reg.sender_handle} - {1'b0, first_sel};
        in_win    = !diff[HANDLE_W] && (diff[HANDLE_W-1:0] < HANDLE_W'(count_sel));
        pos       = base_sel + diff[POS_W-1:0];
        pos_ok    = 32'(pos) < 32'(TABLE_DEPTH);
        pos_wide  = PW'(pos);
        s1_addr   = pos_wide[AW-1:0];
        s1_range  = !kind_ok || (!s1_single && !(in_win && pos_ok));
    end

    // stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg     <= s1_req_reg.operation;
            s2_kind_reg   <= s1_req_reg.event_kind;
            s2_value_reg  <= s1_req_reg.new_value;
            s2_single_reg <= s1_single;
            s2_range_reg  <= s1_range;
            s2_addr_reg   <= s1_addr;
        end
    end

    // stored value, with the write of the item just ahead forwarded
    assign tab_stored    = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                           : tab_rdata;
    assign single_stored = single_reg[s2_kind_reg];

    // result and write decision
    always_comb
    begin
        result.status      = ST_OK;
        result.found_value = '0;
        tab_wr             = 1'b0;
        single_wr          = 1'b0;
        if (s2_range_reg)
        begin
            result.status = ST_RANGE;
        end
        else if (s2_single_reg)
        begin
            if (s2_op_reg == OP_LOOKUP)
            begin
                result.found_value = single_stored;
            end
            else if (s2_value_reg == EMPTY_VALUE)
            begin
                result.status = ST_CONFLICT;
            end
            else if (single_stored == EMPTY_VALUE)
            begin
                single_wr = 1'b1;
            end
            else if (single_stored != s2_value_reg)
            begin
                result.status = ST_CONFLICT;
            end
        end
        else if (s2_op_reg == OP_LOOKUP)
        begin
            if (tab_stored == EMPTY_VALUE)
            begin
                result.status = ST_NOT_FOUND;
            end
            else
            begin
                result.found_value = tab_stored;
            end
        end
        else if (s2_value_reg == EMPTY_VALUE)
        begin
            result.status = ST_CONFLICT;
        end
        else if ((tab_stored != EMPTY_VALUE) && (tab_stored != s2_value_reg))
        begin
            result.status = ST_CONFLICT;
        end
        else
        begin
            tab_wr = 1'b1;
        end
    end

    // single value store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_KINDS; k++)
            begin
                single_reg[k] <= EMPTY_VALUE;
            end
        end
        else if (fire && single_wr)
        begin
            single_reg[s2_kind_reg] <= s2_value_reg;
        end
    end

    // forwarding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fwd_valid_reg <= fire && tab_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= s2_value_reg;
        end
    end

    // table memory, shared between the clearing sweep and write-back
    assign tab_we    = clearing_reg || (fire && tab_wr);
    assign tab_waddr = clearing_reg ? clr_addr_reg : s2_addr_reg;
    assign tab_wdata = clearing_reg ? EMPTY_VALUE : s2_value_reg;

    sdlm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (advance),
        .raddr (s1_addr),
        .rdata (tab_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // no item is in flight when the clearing sweep ends
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> !s1_valid_reg && !s2_valid_reg && !rsp_valid_reg)
        else $error("item in flight during clearing sweep");

    // write-back never stores the empty mark
    a_no_empty_write: assert property (@(posedge clk) disable iff (!rst_n)
        tab_we && !clearing_reg |-> tab_wdata != EMPTY_VALUE)
        else $error("empty mark written by an add");

    // a decided item always reaches the output register
    a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s2_valid_reg |=> rsp_valid_reg)
        else $error("stage 2 item lost");

    // only a successful transfer carries a value
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_data_reg.status != ST_OK) |-> rsp_data_reg.found_value == '0)
        else $error("value returned with an error status");

endmodule
